### rtl/msmv_pkg.sv
// Package: shared types and constants for the masked sparse matvec block.
`default_nettype none
package msmv_pkg;

  localparam int VECTOR_DEPTH = 1024;
  localparam int ADDR_W       = $clog2(VECTOR_DEPTH);
  localparam int CFG_IDX_W    = 2;

  // opcodes of an input beat
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_ENTRY = 2'd1;
  localparam logic [1:0] OP_EMPTY = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OLD_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROD_SCALE = 2'd2;

  // classified command kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [9:0]         column;
    logic [9:0]         row;
    logic signed [31:0] value;
    logic signed [31:0] mask_value;
    logic signed [31:0] old_out;
    logic               last_in_row;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         out_row;
    logic signed [31:0] new_out;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [9:0]         column;
    logic [9:0]         row;
    logic signed [31:0] value;
    logic signed [31:0] mask_value;
    logic signed [31:0] old_out;
    logic               last_in_row;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/msmv_front.sv
// Front end: takes input beats, classifies them and queues commands.
`default_nettype none
module msmv_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire msmv_pkg::in_item_t in_data,
  output logic                   q_valid,
  output msmv_pkg::cmd_t         q_head,
  input  wire logic              q_pop
);

  msmv_pkg::cmd_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       keep;
  msmv_pkg::cmd_t cmd;

  // classify: unused opcode is dropped
  always_comb begin
    cmd.column      = in_data.column;
    cmd.row         = in_data.row;
    cmd.value       = in_data.value;
    cmd.mask_value  = in_data.mask_value;
    cmd.old_out     = in_data.old_out;
    cmd.last_in_row = in_data.last_in_row;
    keep            = 1'b1;
    case (in_data.opcode)
      msmv_pkg::OP_LOAD:  cmd.kind = msmv_pkg::KIND_LOAD;
      msmv_pkg::OP_ENTRY: cmd.kind = msmv_pkg::KIND_ENTRY;
      msmv_pkg::OP_EMPTY: cmd.kind = msmv_pkg::KIND_EMPTY;
      default: begin
        cmd.kind = msmv_pkg::KIND_LOAD;
        keep     = 1'b0;
      end
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count != 2'd0);
  assign q_head   = entries[rd_ptr];

  // two-entry queue
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule
`default_nettype wire

### rtl/msmv_back.sv
// Back end: stores, masked accumulation, row update and output register.
`default_nettype none
module msmv_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              q_valid,
  input  wire msmv_pkg::cmd_t                    q_head,
  output logic                                   q_pop,
  input  wire logic                              cfg_en,
  input  wire logic [msmv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [31:0]                       cfg_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output msmv_pkg::out_item_t                    out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_FMUL = 3'd3;
  localparam logic [2:0] S_FSUM = 3'd4;

  logic [2:0] state;
  msmv_pkg::cmd_t cur;

  logic signed [31:0] threshold;
  logic signed [31:0] old_scale;
  logic signed [31:0] prod_scale;

  logic [31:0] vec_mem      [msmv_pkg::VECTOR_DEPTH];
  logic [31:0] mask_row_mem [msmv_pkg::VECTOR_DEPTH];
  logic [31:0] mask_col_mem [msmv_pkg::VECTOR_DEPTH];
  logic [31:0] vec_rd;
  logic [31:0] mask_row_rd;
  logic [31:0] mask_col_rd;

  logic signed [63:0] product;
  logic               hit;
  logic [63:0]        row_sum;
  logic signed [63:0] t_prod;
  logic signed [63:0] lo_prod;
  logic signed [63:0] old_prod;

  logic               load_pop;
  logic signed [64:0] lo_wide;
  logic signed [63:0] total;
  logic signed [31:0] result;
  logic               sat;
  logic               out_free;

  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign load_pop = q_pop && (q_head.kind == msmv_pkg::KIND_LOAD);
  assign lo_wide  = $signed(prod_scale) * $signed({1'b0, row_sum[31:0]});

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= 32'sd1;
      old_scale  <= 32'sd0;
      prod_scale <= 32'sd65536;
    end else if (cfg_en) begin
      case (cfg_index)
        msmv_pkg::REG_THRESHOLD:  threshold  <= cfg_data;
        msmv_pkg::REG_OLD_SCALE:  old_scale  <= cfg_data;
        msmv_pkg::REG_PROD_SCALE: prod_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // stores: written on load, read at the queue head
  always_ff @(posedge clk) begin
    if (load_pop) begin
      vec_mem[q_head.column[msmv_pkg::ADDR_W-1:0]]      <= q_head.value;
      mask_row_mem[q_head.column[msmv_pkg::ADDR_W-1:0]] <= q_head.mask_value;
      mask_col_mem[q_head.column[msmv_pkg::ADDR_W-1:0]] <= q_head.mask_value;
    end
    vec_rd      <= vec_mem[q_head.column[msmv_pkg::ADDR_W-1:0]];
    mask_col_rd <= mask_col_mem[q_head.column[msmv_pkg::ADDR_W-1:0]];
    mask_row_rd <= mask_row_mem[q_head.row[msmv_pkg::ADDR_W-1:0]];
  end

  // final sum and saturation
  always_comb begin
    total = 64'sd0;
    sat   = 1'b0;
    if (t_prod > 64'sh2_0000_0000) begin
      result = 32'sh7FFF_FFFF;
      sat    = 1'b1;
    end else if (t_prod < -64'sh2_0000_0000) begin
      result = -32'sh8000_0000;
      sat    = 1'b1;
    end else begin
      total = (t_prod <<< 16) + (lo_prod >>> 16) + (old_prod >>> 16);
      if (total > 64'sh7FFF_FFFF) begin
        result = 32'sh7FFF_FFFF;
        sat    = 1'b1;
      end else if (total < -64'sh8000_0000) begin
        result = -32'sh8000_0000;
        sat    = 1'b1;
      end else begin
        result = total[31:0];
      end
    end
  end

  // output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FSUM && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (state == S_MUL) begin
      product <= $signed(cur.value) * $signed(vec_rd);
      hit     <= ($signed(mask_row_rd) < threshold) && ($signed(mask_col_rd) < threshold);
    end
    if (state == S_FMUL) begin
      t_prod   <= prod_scale * $signed(row_sum[63:32]);
      lo_prod  <= lo_wide[63:0];
      old_prod <= old_scale * cur.old_out;
    end
    if (state == S_FSUM && out_free) begin
      out_data.out_row   <= cur.row;
      out_data.new_out   <= result;
      out_data.saturated <= sat;
    end
    if (rst) begin
      state   <= S_IDLE;
      row_sum <= 64'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_head.kind)
              msmv_pkg::KIND_ENTRY: state <= S_MUL;
              msmv_pkg::KIND_EMPTY: state <= S_FMUL;
              default:              state <= S_IDLE;
            endcase
          end
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          if (hit) begin
            // floor shift of the signed product, then wrap into the sum
            row_sum <= row_sum + $unsigned(product >>> 16);
          end
          state <= cur.last_in_row ? S_FMUL : S_IDLE;
        end
        S_FMUL: begin
          row_sum <= 64'd0;
          state   <= S_FSUM;
        end
        S_FSUM: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/masked_sparse_matvec_axpby_top.sv
// Top level of the masked sparse matvec block with axpby row update.
//
// Input channel in_valid/in_ready/in_data carries one beat per item:
// opcode 0 loads a vector element and mask word, 1 is a CSR matrix entry,
// 2 an empty row; opcode 3 is taken and dropped. Output channel
// out_valid/out_ready/out_data gives one beat per finished row (last entry
// or empty row) with the Q16.16 row value and a saturation flag.
// cfg_en/cfg_index/cfg_data write threshold, old scale and product scale;
// the user must do so only while the block is idle; no logic enforces it.
// A two-entry queue parts the front end from the execution sequencer.
// Execution steps: a load is written to the stores when popped; an entry
// passes store read, multiply and accumulate; an entry ending a row adds
// the scaling multiply and sum/saturate steps, which an empty row runs on
// its own; the sequencer handles one command at a time. The result is
// registered in the output register at the sum/saturate step.
// Reset clears control, row sum and registers to their reset values; the
// stores hold nothing defined until loaded. When the receiver stalls the
// result waits in the output register; the queue keeps taking beats until
// full.
`default_nettype none
module masked_sparse_matvec_axpby_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire msmv_pkg::in_item_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output msmv_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_en,
  input  wire logic [msmv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data
);

  logic           q_valid;
  logic           q_pop;
  msmv_pkg::cmd_t q_head;

  msmv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  msmv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
